### rtl/sliding_wiener_denoiser_unit_macros.svh
// ----------------------------------------------------------------------------
// Sliding Wiener denoiser assertion macros
// Shared concurrent assertion forms, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WIENER_DENOISER_UNIT_MACROS_SVH
`define SLIDING_WIENER_DENOISER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// implication checked on every edge outside reset
`define SWD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define SWD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SWD_ASSERT_IMP(label, clk, rst, ante, cons)
`define SWD_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### rtl/swd_pkg.sv
// ----------------------------------------------------------------------------
// Sliding Wiener denoiser package
// Default sizes used by the denoiser unit.
// ----------------------------------------------------------------------------
package swd_pkg;
  localparam int MAX_WINDOW_DEF  = 256;
  localparam int SAMPLE_BITS_DEF = 24;
  localparam int GAIN_FRAC_DEF   = 16;
  localparam int WLEN_BITS       = 9;
  localparam logic [WLEN_BITS-1:0] WLEN_RESET = 9'd16;
endpackage

### rtl/sliding_wiener_denoiser_unit.sv
// ----------------------------------------------------------------------------
// Sliding Wiener denoiser unit
// Windowed mean and variance estimate with a Wiener gain toward the newest
// sample.
// ----------------------------------------------------------------------------
// A request that completes a full window runs the history reads and sum
// updates (S_RD, S_RD1, S_RD2, S_UPD, S_UPD2, S_UPD3); then one shared
// restoring divider, one quotient bit per cycle, runs the three window
// divisions and the gain division (skipped when signal plus noise is zero,
// giving a gain of zero), then S_MUL forms the gain product and S_OUT the
// output. While the window is still filling the result is given from S_UPD3
// with no divisions. One shared multiplier does the squares and the gain
// product. The block holds in_stall high while a request is at work and while
// its result waits in the output register, so the next sample is taken the
// cycle after the result is accepted. Writing window_length restarts the fill;
// results carry valid_res low until the window holds window_length samples
// (clamped to 2..MAX_WINDOW).
module sliding_wiener_denoiser_unit #(
  parameter int MAX_WINDOW         = swd_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS        = swd_pkg::SAMPLE_BITS_DEF,
  parameter int GAIN_FRACTION_BITS = swd_pkg::GAIN_FRAC_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [swd_pkg::WLEN_BITS-1:0] cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] denoised,
  output logic                          valid_res
);
  import swd_pkg::*;
  `include "sliding_wiener_denoiser_unit_macros.svh"

  localparam int AW  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CW  = $clog2(MAX_WINDOW + 1);
  localparam int SB  = SAMPLE_BITS;
  localparam int DB  = SB + 1;                  // difference width
  localparam int PW  = 2 * DB;                  // square width
  localparam int SUM_BITS = PW + CW + 1;        // accumulators
  localparam int NW  = SUM_BITS + GAIN_FRACTION_BITS + 1;  // dividend width
  localparam int QC  = $clog2(NW + 1);
  localparam int GW  = GAIN_FRACTION_BITS + 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD    = 4'd1;
  localparam logic [3:0] S_RD2   = 4'd2;
  localparam logic [3:0] S_UPD   = 4'd3;
  localparam logic [3:0] S_DMEAN = 4'd4;
  localparam logic [3:0] S_DSQ   = 4'd5;
  localparam logic [3:0] S_DNS   = 4'd6;
  localparam logic [3:0] S_DGN   = 4'd8;
  localparam logic [3:0] S_MUL   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;
  localparam logic [3:0] S_RD1   = 4'd11;
  localparam logic [3:0] S_UPD2  = 4'd12;
  localparam logic [3:0] S_UPD3  = 4'd13;

  logic [3:0] state;
  logic [WLEN_BITS-1:0] wlen;
  logic [CW-1:0] fill;
  logic [AW-1:0] wptr;
  logic signed [SUM_BITS-1:0] rsum;
  logic [SUM_BITS-1:0] rsq, rdsq;
  logic signed [SB-1:0] x, hold_o, hold_n;
  logic [AW-1:0] raddr;
  logic [SB-1:0] rdata;
  logic ram_we;

  // effective window
  logic [CW:0] weff;
  always_comb begin
    if (wlen < 2) weff = (CW+1)'(2);
    else if ({{(CW+1){1'b0}}, wlen} > (CW+1+WLEN_BITS)'(MAX_WINDOW))
      weff = (CW+1)'(MAX_WINDOW);
    else weff = (CW+1)'(wlen);
  end
  logic full_before;
  assign full_before = ({1'b0, fill} >= weff);

  swd_ram #(.WIDTH(SB), .DEPTH(1 << AW)) u_hist (
    .clk(clk), .we(ram_we), .waddr(wptr), .wdata(x),
    .raddr(raddr), .rdata(rdata)
  );

  // shared multiplier: signed operands of DB bits
  logic signed [DB-1:0] ma, mb;
  logic signed [PW-1:0] mp;
  assign mp = ma * mb;

  // shared divider
  logic [NW-1:0] dq;
  logic [SUM_BITS+1:0] drem;
  logic [SUM_BITS:0] dden;
  logic [QC-1:0] dcnt;
  logic [SUM_BITS+1:0] dtrial;
  assign dtrial = {drem[SUM_BITS:0], dq[NW-1]} - {1'b0, dden};

  logic signed [SB:0] mean;
  logic [PW-1:0] meansq;
  logic [SUM_BITS-1:0] sqdiv, noise, sig;
  logic [GW-1:0] gain;
  logic [PW+GW-1:0] prod;
  logic signed [DB:0] delta;
  logic [DB:0] dmag;
  logic msign;
  logic [SUM_BITS-1:0] rsum_mag;

  assign rsum_mag = rsum[SUM_BITS-1] ? SUM_BITS'(-rsum) : SUM_BITS'(rsum);
  // |newest - mean| always fits below 2^SAMPLE_BITS
  assign dmag = delta[DB] ? -delta : delta;

  // read address for the states that fetch history
  always_comb begin
    raddr = wptr - AW'(1);
    if (state == S_RD) raddr = wptr - weff[AW-1:0];
    else if (state == S_RD1) raddr = wptr - weff[AW-1:0] + AW'(1);
  end
  assign ram_we = (state == S_UPD3);
  assign in_stall = (state != S_IDLE) || out_valid;

  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_UPD:  begin ma = DB'(hold_o);           mb = DB'(hold_o); end
      S_UPD2: begin ma = DB'(hold_n) - DB'(hold_o); mb = ma; end
      S_UPD3: begin ma = DB'(x) - DB'($signed(rdata)); mb = ma; end
      S_DSQ:  begin ma = mean[DB-1:0];          mb = mean[DB-1:0]; end
      S_MUL:  begin ma = dmag[DB-1:0];          mb = DB'(gain); end
      default: begin ma = DB'(x);                mb = DB'(x); end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wlen <= WLEN_RESET;
      fill <= '0;
      wptr <= '0;
      rsum <= '0;
      rsq <= '0;
      rdsq <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (cfg_we) begin
        wlen <= cfg_wdata;
        fill <= '0;
        wptr <= '0;
        rsum <= '0;
        rsq <= '0;
        rdsq <= '0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            x <= sample;
            state <= S_RD;
          end
        end
        S_RD: begin
          // add square of the new sample
          rsq <= rsq + SUM_BITS'($unsigned(mp));
          state <= S_RD1;
        end
        S_RD1: begin
          hold_o <= $signed(rdata);
          state <= S_RD2;
        end
        S_RD2: begin
          hold_n <= $signed(rdata);
          state <= S_UPD;
        end
        S_UPD: begin
          // remove oldest sample once the window is full, add new sample
          if (full_before) begin
            rsum <= rsum - SUM_BITS'(hold_o) + SUM_BITS'(x);
            rsq <= rsq - SUM_BITS'($unsigned(mp));
          end else begin
            rsum <= rsum + SUM_BITS'(x);
          end
          state <= S_UPD2;
        end
        S_UPD2: begin
          if (full_before) rdsq <= rdsq - SUM_BITS'($unsigned(mp));
          state <= S_UPD3;
        end
        S_UPD3: begin
          if (fill != '0) rdsq <= rdsq + SUM_BITS'($unsigned(mp));
          wptr <= wptr + AW'(1);
          if (!full_before) fill <= fill + CW'(1);
          if ({1'b0, fill} + (CW+1)'(1) < weff) begin
            denoised <= '0;
            valid_res <= 1'b0;
            out_valid <= 1'b1;
            state <= S_IDLE;
          end else begin
            // divide |sum| by W
            dq <= NW'(rsum_mag) << (NW - SUM_BITS);
            drem <= '0;
            dden <= (SUM_BITS+1)'(weff);
            dcnt <= QC'(SUM_BITS);
            msign <= rsum[SUM_BITS-1];
            state <= S_DMEAN;
          end
        end
        S_DMEAN, S_DSQ, S_DNS, S_DGN: begin
          if (dcnt != '0) begin
            if (!dtrial[SUM_BITS+1]) begin
              drem <= dtrial;
              dq <= {dq[NW-2:0], 1'b1};
            end else begin
              drem <= {drem[SUM_BITS:0], dq[NW-1]};
              dq <= {dq[NW-2:0], 1'b0};
            end
            dcnt <= dcnt - QC'(1);
          end else begin
            case (state)
              S_DMEAN: begin
                mean <= msign ? -(SB+1)'(dq[SB:0]) : (SB+1)'(dq[SB:0]);
                dq <= NW'(rsq) << (NW - SUM_BITS);
                drem <= '0;
                dcnt <= QC'(SUM_BITS);
                state <= S_DSQ;
              end
              S_DSQ: begin
                sqdiv <= dq[SUM_BITS-1:0];
                meansq <= $unsigned(mp);
                dq <= NW'(rdsq) << (NW - SUM_BITS);
                drem <= '0;
                dden <= (SUM_BITS+1)'({weff - (CW+1)'(1), 1'b0});
                dcnt <= QC'(SUM_BITS);
                state <= S_DNS;
              end
              S_DNS: begin
                noise <= dq[SUM_BITS-1:0];
                if (sqdiv - SUM_BITS'(meansq) > dq[SUM_BITS-1:0])
                  sig <= sqdiv - SUM_BITS'(meansq) - dq[SUM_BITS-1:0];
                else sig <= '0;
                state <= S_DGN;
                dcnt <= '0;
                drem <= '1;
              end
              default: begin
                // S_DGN: first entry sets up, second finishes
                if (drem == '1) begin
                  // dividend is sig scaled by 2^GAIN_FRACTION_BITS
                  dq <= NW'(sig) << (NW - SUM_BITS);
                  drem <= '0;
                  dden <= (SUM_BITS+1)'(sig) + (SUM_BITS+1)'(noise);
                  dcnt <= QC'(SUM_BITS + GAIN_FRACTION_BITS);
                  if (sig == '0 && noise == '0) begin
                    gain <= '0;
                    state <= S_MUL;
                  end
                end else begin
                  gain <= GW'(dq);
                  state <= S_MUL;
                end
                delta <= (DB+1)'(x) - (DB+1)'(mean);
              end
            endcase
          end
        end
        S_MUL: begin
          // |delta| * gain on the shared multiplier
          prod <= (PW+GW)'($unsigned(mp));
          state <= S_OUT;
        end
        S_OUT: begin
          denoised <= delta[DB]
            ? SB'(mean - (SB+1)'(prod >> GAIN_FRACTION_BITS))
            : SB'(mean + (SB+1)'(prod >> GAIN_FRACTION_BITS));
          valid_res <= 1'b1;
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // checks
  `SWD_ASSERT_IMP(a_busy_stall, clk, rst, state != S_IDLE, in_stall)
  `SWD_ASSERT_IMP(a_fill_bound, clk, rst, 1'b1, {1'b0, fill} <= weff)
  `SWD_ASSERT_NEXT(a_hold_out, clk, rst, out_valid && out_stall, out_valid && $stable(denoised))
endmodule

### rtl/swd_ram.sv
// ----------------------------------------------------------------------------
// Sliding Wiener denoiser RAM
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module swd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
